// ----- rtl/lphp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lphp_pkg
// Types, constants and the record builder shared by the header parser modules.
// ----------------------------------------------------------------------------
package lphp_pkg;

  typedef enum logic [2:0] {
    LYR_ETH    = 3'd0,
    LYR_IPV4   = 3'd1,
    LYR_IPV6   = 3'd2,
    LYR_TCP    = 3'd3,
    LYR_UDP    = 3'd4,
    LYR_ICMP   = 3'd5,
    LYR_ICMPV6 = 3'd6
  } layer_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BAD_VER = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  localparam int unsigned STORE_DEPTH = 40;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);

  localparam logic [5:0] CNT_MAX      = 6'd63;
  localparam logic [5:0] ETH_HDR_BYTES = 6'd14;
  localparam logic [5:0] IP4_MIN_HDR  = 6'd20;
  localparam logic [5:0] IP6_HDR_LEN  = 6'd40;
  localparam logic [5:0] TCP_MIN_HDR  = 6'd20;
  localparam logic [5:0] L4_SHORT_HDR = 6'd8;

  localparam logic [3:0]  IP4_VERSION = 4'd4;
  localparam logic [3:0]  IP6_VERSION = 4'd6;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  PROTO_ICMP6 = 8'd58;
  localparam logic [31:0] FLOW_MASK   = 32'h0FFF_FFFF;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  typedef struct packed {
    layer_e  layer;
    status_e status;
    logic    last;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

  typedef struct packed {
    layer_e      layer;
    status_e     status;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [15:0] half_a;
    logic [15:0] half_b;
    logic [7:0]  small_field;
    logic        last;
  } rec_t;

  function automatic logic [15:0] be2(store_t h, logic [5:0] p);
    return {h[p], h[p+6'd1]};
  endfunction

  function automatic logic [31:0] be4(store_t h, logic [5:0] p);
    return {h[p], h[p+6'd1], h[p+6'd2], h[p+6'd3]};
  endfunction

  function automatic logic [63:0] be8(store_t h, logic [5:0] p);
    return {be4(h, p), be4(h, p + 6'd4)};
  endfunction

  // Error records carry only layer, status and last.
  function automatic rec_t build_rec(store_t h, desc_t d);
    rec_t r;
    r        = '0;
    r.layer  = d.layer;
    r.status = d.status;
    r.last   = d.last;
    if (d.status == ST_OK) begin
      case (d.layer)
        LYR_ETH: begin
          r.src_low = {16'd0, be2(h, 6'd6), be4(h, 6'd8)};
          r.dst_low = {16'd0, be4(h, 6'd0), be2(h, 6'd4)};
          r.half_a  = be2(h, 6'd12);
        end
        LYR_IPV4: begin
          r.src_low = {32'd0, be4(h, 6'd12)};
          r.dst_low = {32'd0, be4(h, 6'd16)};
          r.word_a  = {h[8], h[9], be2(h, 6'd6)};
          r.word_b  = {be2(h, 6'd4), be2(h, 6'd10)};
          r.half_a  = be2(h, 6'd2);
          r.half_b  = {10'd0, h[0][3:0], 2'b00};
        end
        LYR_IPV6: begin
          r.src_high = be8(h, 6'd8);
          r.src_low  = be8(h, 6'd16);
          r.dst_high = be8(h, 6'd24);
          r.dst_low  = be8(h, 6'd32);
          r.word_a   = be4(h, 6'd0) & FLOW_MASK;
          r.word_b   = {16'd0, h[6], h[7]};
          r.half_a   = be2(h, 6'd4);
        end
        LYR_TCP: begin
          r.src_low     = {16'd0, be2(h, 6'd14), be4(h, 6'd16)};
          r.dst_low     = {56'd0, 2'b00, h[12][7:4], 2'b00};
          r.word_a      = be4(h, 6'd4);
          r.word_b      = be4(h, 6'd8);
          r.half_a      = be2(h, 6'd0);
          r.half_b      = be2(h, 6'd2);
          r.small_field = h[13];
        end
        LYR_UDP: begin
          r.word_a = be4(h, 6'd4);
          r.half_a = be2(h, 6'd0);
          r.half_b = be2(h, 6'd2);
        end
        LYR_ICMP, LYR_ICMPV6: begin
          r.word_a      = be4(h, 6'd4);
          r.word_b      = {16'd0, h[0], h[1]};
          r.half_a      = be2(h, 6'd2);
          r.small_field = h[0];
        end
        default: begin
          r.src_low = '0;
        end
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lphp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lphp_front
// Byte intake: layer tracking, header store and record requests.
// ----------------------------------------------------------------------------
module lphp_front import lphp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_end_i,
  input  wire logic [2:0] occ_i,
  output logic            in_ready_o,
  output push_t           push_o,
  output store_t          store_o
);

  localparam logic [15:0] LEN_CAP = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  layer_e                 layer_q, layer_d;
  logic [5:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic                   lim_q, lim_d;
  logic                   done_q, done_d;
  store_t                 hdr_q;
  store_t                 view;

  logic    ev_v_q, ev_v_d, ev_two_q, ev_two_d, sec_v_q, sec_v_d;
  desc_t   ev0_q, ev0_d, ev1_q, ev1_d, sec_q;

  logic    accept;
  logic    fe_v, te_v, finish;
  status_e fe_st;
  layer_e  te_layer;
  logic [5:0]  ihl, tcp_hl;
  logic [15:0] etype, total, plen;
  logic [3:0]  room;

  function automatic logic [LENGTH_BITS-1:0] sat_len(logic [15:0] v);
    return LENGTH_BITS'((v > LEN_CAP) ? LEN_CAP : v);
  endfunction

  // two slots worst case per byte; output capacity is QDEPTH plus the out reg
  assign room       = 4'(occ_i) + 4'(ev_v_q) + 4'(sec_v_q);
  assign in_ready_o = !ev_two_q && (room <= 4'(QDEPTH - 1));
  assign accept     = in_valid_i && in_ready_o;

  // store as it looks with the current byte in place
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      view[k] = (cnt_q == 6'(k)) ? data_byte_i : hdr_q[k];
    end
  end

  assign ihl    = {view[0][3:0], 2'b00};
  assign tcp_hl = {view[12][7:4], 2'b00};
  assign etype  = {view[12], view[13]};
  assign total  = {view[2], view[3]};
  assign plen   = {view[4], view[5]};

  always_comb begin
    layer_d  = layer_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    lim_d    = lim_q;
    done_d   = done_q;
    fe_v     = 1'b0;
    fe_st    = ST_OK;
    te_v     = 1'b0;
    te_layer = layer_q;
    finish   = 1'b0;
    if (accept && !done_q) begin
      if (cnt_q != CNT_MAX) cnt_d = cnt_q + 6'd1;
      if (layer_q >= LYR_TCP && lim_q && left_q != '0) begin
        left_d = left_q - LENGTH_BITS'(1);
      end
      case (layer_q)
        LYR_ETH: begin
          if (cnt_d == ETH_HDR_BYTES) begin
            fe_v = 1'b1;
            if (etype == ETYPE_IPV4) begin
              layer_d = LYR_IPV4;
              cnt_d   = '0;
            end else if (etype == ETYPE_IPV6) begin
              layer_d = LYR_IPV6;
              cnt_d   = '0;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        LYR_IPV4: begin
          if (cnt_d == IP4_MIN_HDR) begin
            if (view[0][7:4] != IP4_VERSION) begin
              fe_v   = 1'b1;
              fe_st  = ST_BAD_VER;
              done_d = 1'b1;
            end else if (ihl < IP4_MIN_HDR) begin
              fe_v   = 1'b1;
              fe_st  = ST_BAD_LEN;
              done_d = 1'b1;
            end else if (ihl == IP4_MIN_HDR) begin
              finish = 1'b1;
            end
          end else if (cnt_d > IP4_MIN_HDR && cnt_d == ihl) begin
            finish = 1'b1;
          end
          if (finish) begin
            fe_v   = 1'b1;
            lim_d  = 1'b0;
            left_d = '0;
            if (total > 16'(ihl)) begin
              lim_d  = 1'b1;
              left_d = sat_len(total - 16'(ihl));
            end
            cnt_d = '0;
            if (frame_end_i) begin
              done_d = 1'b1;
            end else begin
              case (view[9])
                PROTO_TCP:  layer_d = LYR_TCP;
                PROTO_UDP:  layer_d = LYR_UDP;
                PROTO_ICMP: layer_d = LYR_ICMP;
                default:    done_d  = 1'b1;
              endcase
            end
          end
        end
        LYR_IPV6: begin
          if (cnt_d == IP6_HDR_LEN) begin
            fe_v = 1'b1;
            if (view[0][7:4] != IP6_VERSION) begin
              fe_st  = ST_BAD_VER;
              done_d = 1'b1;
            end else begin
              lim_d  = 1'b1;
              left_d = sat_len(plen);
              cnt_d  = '0;
              if (frame_end_i || plen == 16'd0) begin
                done_d = 1'b1;
              end else begin
                case (view[6])
                  PROTO_TCP:   layer_d = LYR_TCP;
                  PROTO_UDP:   layer_d = LYR_UDP;
                  PROTO_ICMP:  layer_d = LYR_ICMP;
                  PROTO_ICMP6: layer_d = LYR_ICMPV6;
                  default:     done_d  = 1'b1;
                endcase
              end
            end
          end
        end
        LYR_TCP: begin
          if (cnt_d == TCP_MIN_HDR) begin
            fe_v   = 1'b1;
            done_d = 1'b1;
            if (tcp_hl < TCP_MIN_HDR) fe_st = ST_BAD_LEN;
          end
        end
        LYR_UDP, LYR_ICMP, LYR_ICMPV6: begin
          if (cnt_d == L4_SHORT_HDR) begin
            fe_v   = 1'b1;
            done_d = 1'b1;
          end
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
      // length limit ran out, or frame ended inside a header
      if (!done_d) begin
        if ((layer_d >= LYR_TCP && lim_d && left_d == '0) || frame_end_i) begin
          te_v     = 1'b1;
          te_layer = layer_d;
          done_d   = 1'b1;
        end
      end
    end
    if (accept && frame_end_i) begin
      layer_d = LYR_ETH;
      cnt_d   = '0;
      left_d  = '0;
      lim_d   = 1'b0;
      done_d  = 1'b0;
    end
  end

  always_comb begin
    ev_v_d   = accept && (fe_v || te_v);
    ev_two_d = accept && fe_v && te_v;
    ev1_d    = '{layer: te_layer, status: ST_TRUNC, last: 1'b1};
    if (fe_v) begin
      ev0_d = '{layer: layer_q, status: fe_st, last: !te_v};
    end else begin
      ev0_d = ev1_d;
    end
    sec_v_d = ev_v_q && ev_two_q;
  end

  // first request reads the store in the cycle after its last byte
  assign push_o.valid = ev_v_q || sec_v_q;
  assign push_o.desc  = ev_v_q ? ev0_q : sec_q;
  assign store_o      = hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q  <= LYR_ETH;
      cnt_q    <= '0;
      left_q   <= '0;
      lim_q    <= 1'b0;
      done_q   <= 1'b0;
      ev_v_q   <= 1'b0;
      ev_two_q <= 1'b0;
      sec_v_q  <= 1'b0;
    end else begin
      layer_q  <= layer_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      lim_q    <= lim_d;
      done_q   <= done_d;
      ev_v_q   <= ev_v_d;
      ev_two_q <= ev_two_d;
      sec_v_q  <= sec_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !done_q && cnt_q < 6'(STORE_DEPTH)) begin
      hdr_q[cnt_q] <= data_byte_i;
    end
    ev0_q <= ev0_d;
    ev1_q <= ev1_d;
    if (ev_v_q) sec_q <= ev1_q;
  end

endmodule
`default_nettype wire

// ----- rtl/lphp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lphp_queue
// Record queue with a registered output stage.
// ----------------------------------------------------------------------------
module lphp_queue import lphp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_v_i,
  input  rec_t      push_rec_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output rec_t      out_rec_o,
  output logic [2:0] occ_o
);

  rec_t              mem_q [QDEPTH];
  rec_t              out_q;
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [2:0]        mc_q, mc_d;
  logic              out_v_q, load;

  assign load = (mc_q != 3'd0) && (!out_v_q || out_ready_i);
  assign mc_d = mc_q + 3'(push_v_i) - 3'(load);

  always_ff @(posedge clk_i) begin
    if (push_v_i) mem_q[wr_q] <= push_rec_i;
    if (load) out_q <= mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      mc_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      mc_q <= mc_d;
      if (push_v_i) wr_q <= wr_q + QPTR_W'(1);
      if (load) begin
        rd_q    <= rd_q + QPTR_W'(1);
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rec_o   = out_q;
  assign occ_o       = mc_q + 3'(out_v_q);

endmodule
`default_nettype wire

// ----- rtl/layered_packet_header_parser.sv -----
`default_nettype none
// Records: the second record of a pair is pushed to the queue in the cycle after the first.
// Throughput: one byte per cycle unless held off; a byte that yields two records holds input off.
// Input also holds off once queued plus in-flight records take 4 of the 5 record slots.
// Reset: parser returns to the Ethernet layer and the record queue empties.
// ----------------------------------------------------------------------------
// layered_packet_header_parser
// Ethernet / IPv4 / IPv6 / TCP / UDP / ICMP header parser, one byte per request.
// ----------------------------------------------------------------------------
module layered_packet_header_parser import lphp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       layer_o,
  output logic [1:0]       status_o,
  output logic [63:0]      src_high_o,
  output logic [63:0]      src_low_o,
  output logic [63:0]      dst_high_o,
  output logic [63:0]      dst_low_o,
  output logic [31:0]      word_a_o,
  output logic [31:0]      word_b_o,
  output logic [15:0]      half_a_o,
  output logic [15:0]      half_b_o,
  output logic [7:0]       small_field_o,
  output logic             last_of_item_o
);

  push_t      push;
  store_t     store;
  rec_t       rec, out_rec;
  logic [2:0] occ;

  lphp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .occ_i       (occ),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .store_o     (store)
  );

  assign rec = build_rec(store, push.desc);

  lphp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_v_i    (push.valid),
    .push_rec_i  (rec),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rec_o   (out_rec),
    .occ_o       (occ)
  );

  assign layer_o        = out_rec.layer;
  assign status_o       = out_rec.status;
  assign src_high_o     = out_rec.src_high;
  assign src_low_o      = out_rec.src_low;
  assign dst_high_o     = out_rec.dst_high;
  assign dst_low_o      = out_rec.dst_low;
  assign word_a_o       = out_rec.word_a;
  assign word_b_o       = out_rec.word_b;
  assign half_a_o       = out_rec.half_a;
  assign half_b_o       = out_rec.half_b;
  assign small_field_o  = out_rec.small_field;
  assign last_of_item_o = out_rec.last;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 3'(QDEPTH + 1))
    else $error("record queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid && !push.desc.last |=> push.valid && push.desc.last)
    else $error("second record of a pair missing");

  a_pair_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid && !push.desc.last |-> !in_ready_o)
    else $error("input taken while a record pair drains");

endmodule
`default_nettype wire

// ----- test/layered_packet_header_parser_test.sv -----
// ----------------------------------------------------------------------------
// layered_packet_header_parser_test
// Feeds Ethernet/IPv4/IPv6/TCP/UDP/ICMP frames byte by byte, directed cases
// first and then random frames, with random gaps on both sides. Records
// are predicted in the testbench and compared field by field in order.
// ----------------------------------------------------------------------------
module layered_packet_header_parser_test;
  import lphp_pkg::*;

  // Predicts the header records and checks the records that come out.
  class header_scoreboard;
    rec_t        pending_q[$];
    int          errors;
    layer_e      cur_layer;
    int          byte_cnt;
    logic [7:0]  hdr[STORE_DEPTH];
    int          l4_left;
    bit          limit_on;
    bit          parse_done;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      cur_layer  = LYR_ETH;
      byte_cnt   = 0;
      l4_left    = 0;
      limit_on   = 0;
      parse_done = 0;
    endfunction

    function logic [63:0] grab(int pos, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) begin
        v = (v << 8) | ((pos + i < STORE_DEPTH) ? hdr[pos + i] : 8'h00);
      end
      return v;
    endfunction

    function rec_t err_rec(layer_e l, status_e s);
      rec_t r;
      r        = '0;
      r.layer  = l;
      r.status = s;
      return r;
    endfunction

    function void enter(layer_e l);
      cur_layer = l;
      byte_cnt  = 0;
    endfunction

    function void set_limit(int amount);
      limit_on = 1;
      l4_left  = (amount > 65535) ? 65535 : amount;
    endfunction

    function void enter_l4(logic [7:0] proto, bit v6);
      if (proto == PROTO_TCP) enter(LYR_TCP);
      else if (proto == PROTO_UDP) enter(LYR_UDP);
      else if (proto == PROTO_ICMP) enter(LYR_ICMP);
      else if (v6 && proto == PROTO_ICMP6) enter(LYR_ICMPV6);
      else parse_done = 1;
    endfunction

    function void note_request(logic [7:0] b, logic fend);
      rec_t        r;
      rec_t        recs[$];
      int          cnt;
      int          ihl;
      int          hl;
      int          total;
      layer_e      lyr;
      logic [15:0] etype;
      bit          finish;
      if (!parse_done) begin
        cnt = byte_cnt;
        lyr = cur_layer;
        if (cnt < STORE_DEPTH) hdr[cnt] = b;
        if (cnt < 63) byte_cnt = cnt + 1;
        cnt = byte_cnt;
        if (lyr >= LYR_TCP && limit_on && l4_left > 0) l4_left--;
        r       = '0;
        r.layer = lyr;
        case (lyr)
          LYR_ETH: begin
            if (cnt == 14) begin
              etype    = 16'(grab(12, 2));
              r.src_low = grab(6, 6);
              r.dst_low = grab(0, 6);
              r.half_a  = etype;
              recs.push_back(r);
              if (etype == ETYPE_IPV4) enter(LYR_IPV4);
              else if (etype == ETYPE_IPV6) enter(LYR_IPV6);
              else parse_done = 1;
            end
          end
          LYR_IPV4: begin
            ihl    = hdr[0][3:0] * 4;
            finish = 0;
            if (cnt == 20) begin
              if (hdr[0][7:4] != IP4_VERSION) begin
                recs.push_back(err_rec(LYR_IPV4, ST_BAD_VER));
                parse_done = 1;
              end else if (ihl < 20) begin
                recs.push_back(err_rec(LYR_IPV4, ST_BAD_LEN));
                parse_done = 1;
              end else if (ihl == 20) begin
                finish = 1;
              end
            end else if (cnt > 20 && cnt == ihl) begin
              finish = 1;
            end
            if (finish) begin
              total     = int'(grab(2, 2));
              r.src_low = grab(12, 4);
              r.dst_low = grab(16, 4);
              r.word_a  = {hdr[8], hdr[9], 16'(grab(6, 2))};
              r.word_b  = {16'(grab(4, 2)), 16'(grab(10, 2))};
              r.half_a  = 16'(total);
              r.half_b  = 16'(ihl);
              recs.push_back(r);
              limit_on = 0;
              l4_left  = 0;
              if (total > ihl) set_limit(total - ihl);
              if (fend) parse_done = 1;
              else enter_l4(hdr[9], 0);
            end
          end
          LYR_IPV6: begin
            if (cnt == 40) begin
              if (hdr[0][7:4] != IP6_VERSION) begin
                recs.push_back(err_rec(LYR_IPV6, ST_BAD_VER));
                parse_done = 1;
              end else begin
                total      = int'(grab(4, 2));
                r.src_high = grab(8, 8);
                r.src_low  = grab(16, 8);
                r.dst_high = grab(24, 8);
                r.dst_low  = grab(32, 8);
                r.word_a   = 32'(grab(0, 4) & 64'h0FFF_FFFF);
                r.word_b   = {16'd0, hdr[6], hdr[7]};
                r.half_a   = 16'(total);
                recs.push_back(r);
                set_limit(total);
                if (fend || total == 0) parse_done = 1;
                else enter_l4(hdr[6], 1);
              end
            end
          end
          LYR_TCP: begin
            if (cnt == 20) begin
              hl = hdr[12][7:4] * 4;
              if (hl < 20) begin
                recs.push_back(err_rec(LYR_TCP, ST_BAD_LEN));
              end else begin
                r.src_low     = (grab(14, 2) << 32) | (grab(16, 2) << 16) | grab(18, 2);
                r.dst_low     = 64'(hl);
                r.word_a      = 32'(grab(4, 4));
                r.word_b      = 32'(grab(8, 4));
                r.half_a      = 16'(grab(0, 2));
                r.half_b      = 16'(grab(2, 2));
                r.small_field = hdr[13];
                recs.push_back(r);
              end
              parse_done = 1;
            end
          end
          LYR_UDP: begin
            if (cnt == 8) begin
              r.word_a = 32'(grab(4, 4));
              r.half_a = 16'(grab(0, 2));
              r.half_b = 16'(grab(2, 2));
              recs.push_back(r);
              parse_done = 1;
            end
          end
          LYR_ICMP, LYR_ICMPV6: begin
            if (cnt == 8) begin
              r.word_a      = 32'(grab(4, 4));
              r.word_b      = {16'd0, hdr[0], hdr[1]};
              r.half_a      = 16'(grab(2, 2));
              r.small_field = hdr[0];
              recs.push_back(r);
              parse_done = 1;
            end
          end
          default: parse_done = 1;
        endcase
        if (!parse_done) begin
          if ((cur_layer >= LYR_TCP && limit_on && l4_left == 0) || fend) begin
            recs.push_back(err_rec(cur_layer, ST_TRUNC));
            parse_done = 1;
          end
        end
      end
      if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
      foreach (recs[i]) pending_q.push_back(recs[i]);
      if (fend) restart();
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("record with none pending: %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.layer != want.layer || got.status != want.status ||
          got.src_high != want.src_high || got.src_low != want.src_low ||
          got.dst_high != want.dst_high || got.dst_low != want.dst_low ||
          got.word_a != want.word_a || got.word_b != want.word_b ||
          got.half_a != want.half_a || got.half_b != want.half_b ||
          got.small_field != want.small_field || got.last != want.last) begin
        errors++;
        if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  layer_o;
  logic [1:0]  status_o;
  logic [63:0] src_high_o, src_low_o, dst_high_o, dst_low_o;
  logic [31:0] word_a_o, word_b_o;
  logic [15:0] half_a_o, half_b_o;
  logic [7:0]  small_field_o;
  logic        last_of_item_o;

  header_scoreboard sb = new();
  logic [7:0] byte_q[$];
  bit         end_q[$];
  int         sent_cnt = 0;
  int         idle_cycles = 0;
  bit         held_once = 0;

  layered_packet_header_parser dut (.*);

  always #6 clk_i = ~clk_i;

  // monitor both handshakes and the watchdog
  always @(posedge clk_i) begin
    rec_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(data_byte_i, frame_end_i);
        sent_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        got.layer       = layer_e'(layer_o);
        got.status      = status_e'(status_o);
        got.src_high    = src_high_o;
        got.src_low     = src_low_o;
        got.dst_high    = dst_high_o;
        got.dst_low     = dst_low_o;
        got.word_a      = word_a_o;
        got.word_b      = word_b_o;
        got.half_a      = half_a_o;
        got.half_b      = half_b_o;
        got.small_field = small_field_o;
        got.last        = last_of_item_o;
        sb.check_record(got);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [3:0] other_nibble(int avoid);
    int v;
    v = $urandom_range(0, 14);
    if (v >= avoid) v++;
    return 4'(v);
  endfunction

  // etype_sel: 0 ipv4, 1 ipv6, else random. len_mode: 0 exact, 1 short, 2 random, 3 zero.
  // keep: 0 whole frame, >0 cut to that many bytes, <0 append that many extra bytes.
  task automatic add_frame(int etype_sel, bit ver_ok, int ihl_nib, int proto,
                           int tcp_off, int len_mode, int keep);
    logic [7:0]  f[$];
    logic [15:0] len;
    int          l4len;
    int          pay;
    int          ihl;
    repeat (12) f.push_back(8'($urandom));
    pay   = $urandom_range(0, 4);
    l4len = (proto == PROTO_TCP) ? ((tcp_off < 5) ? 20 : tcp_off * 4) : 8;
    if (etype_sel == 0) begin
      f.push_back(8'h08); f.push_back(8'h00);
      ihl = ihl_nib * 4;
      case (len_mode)
        0: len = 16'(((ihl < 20) ? 20 : ihl) + l4len + pay);
        1: len = 16'(ihl + $urandom_range(1, l4len - 1));
        2: len = 16'($urandom);
        default: len = 0;
      endcase
      f.push_back({ver_ok ? IP4_VERSION : other_nibble(4), ihl_nib[3:0]});
      f.push_back(8'($urandom));
      f.push_back(len[15:8]); f.push_back(len[7:0]);
      repeat (5) f.push_back(8'($urandom));
      f.push_back(proto[7:0]);
      repeat (10) f.push_back(8'($urandom));
      for (int i = 20; i < ihl; i++) f.push_back(8'($urandom));
    end else if (etype_sel == 1) begin
      f.push_back(8'h86); f.push_back(8'hDD);
      case (len_mode)
        0: len = 16'(l4len + pay);
        1: len = 16'($urandom_range(1, l4len - 1));
        2: len = 16'($urandom);
        default: len = 0;
      endcase
      f.push_back({ver_ok ? IP6_VERSION : other_nibble(6), 4'($urandom)});
      repeat (3) f.push_back(8'($urandom));
      f.push_back(len[15:8]); f.push_back(len[7:0]);
      f.push_back(proto[7:0]);
      repeat (33) f.push_back(8'($urandom));
    end else begin
      f.push_back(8'($urandom)); f.push_back(8'($urandom));
    end
    if (proto == PROTO_TCP) begin
      repeat (12) f.push_back(8'($urandom));
      f.push_back({tcp_off[3:0], 4'($urandom)});
      for (int i = 13; i < l4len; i++) f.push_back(8'($urandom));
    end else begin
      repeat (8) f.push_back(8'($urandom));
    end
    repeat (pay) f.push_back(8'($urandom));
    if (keep > 0 && keep < f.size()) f = f[0:keep-1];
    if (keep < 0) repeat (-keep) f.push_back(8'($urandom));
    foreach (f[i]) begin
      byte_q.push_back(f[i]);
      end_q.push_back(i == f.size() - 1);
    end
  endtask

  task automatic add_random_frame();
    int          sel, proto, pick, keep, lm, n;
    sel   = ($urandom_range(0, 19) < 9) ? 0 : (($urandom_range(0, 10) < 10) ? 1 : 2);
    pick  = $urandom_range(0, 5);
    proto = (pick == 0) ? PROTO_TCP : (pick == 1) ? PROTO_UDP : (pick == 2) ? PROTO_ICMP :
            (pick == 3) ? PROTO_ICMP6 : (pick == 4) ? PROTO_TCP : $urandom_range(0, 255);
    lm    = $urandom_range(0, 9);
    lm    = (lm < 6) ? 0 : lm - 6;
    pick  = $urandom_range(0, 19);
    keep  = (pick < 14) ? 0 : (pick < 17) ? $urandom_range(1, 70) : -$urandom_range(1, 8);
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        byte_q.push_back(8'($urandom));
        end_q.push_back(i == n - 1);
      end
    end else begin
      add_frame(sel, $urandom_range(0, 9) != 0,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15),
                proto,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15),
                lm, keep);
    end
  endtask

  // receiver: random stalls, bursts with none, one long hold to back up the input
  initial begin
    int stall;
    int recs_seen;
    recs_seen = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = ((recs_seen / 20) % 3 == 1) ? 0 : $urandom_range(0, 11);
      if (!held_once && sent_cnt > 600) begin
        held_once = 1;
        stall     = 300;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      recs_seen++;
    end
  end

  initial begin
    int gap;
    bit burst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames
    add_frame(0, 1, 5, PROTO_TCP, 5, 0, 0);
    add_frame(0, 1, 5, PROTO_UDP, 5, 0, 0);
    add_frame(0, 1, 15, PROTO_ICMP, 5, 0, 0);
    add_frame(0, 1, 5, 99, 5, 0, 0);
    add_frame(0, 0, 5, PROTO_TCP, 5, 0, 0);
    add_frame(0, 1, 3, PROTO_TCP, 5, 0, 0);
    add_frame(0, 1, 5, PROTO_TCP, 2, 0, 0);
    add_frame(0, 1, 5, PROTO_TCP, 15, 1, 0);
    add_frame(0, 1, 5, PROTO_UDP, 5, 3, 0);
    add_frame(0, 1, 5, PROTO_TCP, 5, 0, 34);
    add_frame(1, 1, 5, PROTO_TCP, 15, 0, 0);
    add_frame(1, 1, 5, PROTO_UDP, 5, 1, 0);
    add_frame(1, 1, 5, PROTO_ICMP, 5, 0, 0);
    add_frame(1, 1, 5, PROTO_ICMP6, 5, 0, 0);
    add_frame(1, 1, 5, PROTO_TCP, 5, 3, 0);
    add_frame(1, 0, 5, PROTO_UDP, 5, 0, 0);
    add_frame(1, 1, 5, PROTO_UDP, 5, 0, 54);
    add_frame(1, 1, 5, 250, 5, 2, 0);
    add_frame(0, 1, 5, PROTO_TCP, 5, 0, 14);
    add_frame(1, 1, 5, PROTO_TCP, 5, 0, 14);
    add_frame(2, 1, 5, PROTO_TCP, 5, 0, 0);
    add_frame(0, 1, 5, PROTO_TCP, 5, 0, 5);
    add_frame(0, 1, 5, PROTO_TCP, 5, 0, 1);
    add_frame(0, 1, 5, PROTO_UDP, 5, 2, -6);
    while (byte_q.size() < 1100) add_random_frame();

    burst = 0;
    foreach (byte_q[i]) begin
      if (i == 0 || end_q[i - 1]) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= byte_q[i];
      frame_end_i <= end_q[i];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
    // let the monitor note the last request before looking at the pending list
    @(posedge clk_i);

    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- layered_packet_header_parser.f -----
rtl/lphp_pkg.sv
rtl/lphp_front.sv
rtl/lphp_queue.sv
rtl/layered_packet_header_parser.sv
test/layered_packet_header_parser_test.sv
